[rtl/wdd_pkg.sv]
// shared types for the waypoint delta decoder
`default_nettype none

package wdd_pkg;

   localparam int DATA_W  = 8;
   localparam int COORD_W = 16;

   // one decoded waypoint as it leaves the core
   typedef struct packed {
      logic                      last;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } rsp_item_type;

endpackage

`default_nettype wire

[rtl/wdd_rsp_skid.sv]
// output register with skid stage for decoded waypoints
`default_nettype none

module wdd_rsp_skid (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   input  wdd_pkg::rsp_item_type in_item,
   output logic                 in_ready,
   output logic                 out_valid,
   output wdd_pkg::rsp_item_type out_item,
   input  wire                  out_ready
);

   logic                  out_v_ff;
   logic                  skid_v_ff;
   wdd_pkg::rsp_item_type out_ff;
   wdd_pkg::rsp_item_type skid_ff;

   // skid slot full means the upstream must hold
   assign in_ready  = !skid_v_ff;
   assign out_valid = out_v_ff;
   assign out_item  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || out_ready) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= in_valid;
         end
      end else if (in_valid && !skid_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || out_ready) begin
         out_ff <= skid_v_ff ? skid_ff : in_item;
      end
      if (out_v_ff && !out_ready && !skid_v_ff) begin
         skid_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

[rtl/waypoint_delta_decoder_core.sv]
// waypoint delta decoder: byte stream in, absolute waypoints out
//
//   channel | dir | tdata (low bit up)             | tuser      | tlast
//   --------+-----+--------------------------------+------------+------------
//   req_    | in  | data_byte[7:0], coord_count    | start_req  | -
//   rsp_    | out | x[15:0], y[15:0]               | -          | last
//
// one item per cycle sustained while the skid stage has room; each waypoint is
// registered into the skid stage once the byte that completes its y is accepted
// flag header bytes sit in a small synchronous ram; its registered read is
// started from the next-state point index so the flag byte is ready in time
// reset clears the control state only; the flag ram is not swept, every flag
// used is written by the header of the same packet first
// rsp_ stalls are absorbed by a skid stage; req_tready drops only when it is full
`default_nettype none

module waypoint_delta_decoder_core #(
   parameter int MAX_COORDS = 256
) (
   input  wire         clock,
   input  wire         reset,
   // input bytes
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [7:0] data_byte, [15:8] coord_count
   input  wire         req_tuser,   // [0] start_req
   // decoded waypoints
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] x, [31:16] y
   output logic        rsp_tlast    // last waypoint of the packet
);

   // flag ram geometry follows from the largest coordinate count
   localparam int FLAG_BYTES = (MAX_COORDS + 7) / 8;
   localparam int FLAG_AW    = (FLAG_BYTES > 1) ? $clog2(FLAG_BYTES) : 1;
   localparam int FLAG_DEPTH = 1 << FLAG_AW;
   // coord_count is eight bits, so the clamp never exceeds 255
   localparam logic [7:0] SAT_COUNT = (MAX_COORDS > 255) ? 8'd255 : 8'(MAX_COORDS);

   // which byte of the point comes next
   typedef enum logic [3:0] {
      PH_X_LO = 4'b0001,
      PH_X_HI = 4'b0010,
      PH_Y_LO = 4'b0100,
      PH_Y_HI = 4'b1000
   } phase_type;

   // payload unpack
   logic [7:0] data_byte;
   logic [7:0] coord_count;
   logic       start_req;
   assign data_byte   = req_tdata[7:0];
   assign coord_count = req_tdata[15:8];
   assign start_req   = req_tuser;

   // decode state
   logic [5:0]  header_left_ff, header_left_in;
   logic [6:0]  points_left_ff, points_left_in;
   logic [6:0]  point_index_ff, point_index_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  low_hold_ff, low_hold_in;
   logic [15:0] x_acc_ff, x_acc_in;
   logic [15:0] y_acc_ff, y_acc_in;

   // flag ram
   logic [7:0]  flag_mem [FLAG_DEPTH];
   logic [7:0]  flag_rd_ff;
   logic        flag_we;
   logic [FLAG_AW-1:0] flag_wr_addr;
   logic [FLAG_AW-1:0] flag_rd_addr;
   logic [6:0]  rd_pm1;
   logic [6:0]  rd_byte_idx;

   // per-item combinational terms
   logic        accept;
   logic [7:0]  count_sat;
   logic [8:0]  count_plus5;
   logic [5:0]  eff_header;
   logic [6:0]  eff_points;
   logic [6:0]  eff_index;
   phase_type   eff_phase;
   logic [6:0]  cur_pm1;
   logic [2:0]  x_bit_sel;
   logic [2:0]  y_bit_sel;
   logic        x_delta;
   logic        y_delta;
   logic [15:0] byte_sext;
   logic        done;
   logic        skid_ready;

   wdd_pkg::rsp_item_type rsp_item;
   wdd_pkg::rsp_item_type rsp_out;

   assign accept = req_tvalid && req_tready;

   // a start byte reframes the packet before the byte itself is used
   always_comb begin
      count_sat   = (coord_count > SAT_COUNT) ? SAT_COUNT : coord_count;
      count_plus5 = {1'b0, count_sat} + 9'd5;
      if (start_req) begin
         eff_header = count_plus5[8:3] + {5'b0, count_sat[0]};
         eff_points = count_sat[7:1];
         eff_index  = 7'd0;
         eff_phase  = PH_X_LO;
      end else begin
         eff_header = header_left_ff;
         eff_points = points_left_ff;
         eff_index  = point_index_ff;
         eff_phase  = phase_ff;
      end
   end

   // flag bits of point k sit at 2(k-1) and 2(k-1)+1; the first point is absolute
   assign cur_pm1   = eff_index - 7'd1;
   assign x_bit_sel = {cur_pm1[1:0], 1'b0};
   assign y_bit_sel = {cur_pm1[1:0], 1'b1};
   assign x_delta   = (eff_index != 7'd0) && flag_rd_ff[x_bit_sel];
   assign y_delta   = (eff_index != 7'd0) && flag_rd_ff[y_bit_sel];
   assign byte_sext = {{8{data_byte[7]}}, data_byte};

   always_comb begin
      header_left_in = eff_header;
      points_left_in = eff_points;
      point_index_in = eff_index;
      phase_in       = eff_phase;
      low_hold_in    = low_hold_ff;
      x_acc_in       = x_acc_ff;
      y_acc_in       = y_acc_ff;
      flag_we        = 1'b0;
      done           = 1'b0;

      if (eff_header != 6'd0) begin
         // header byte: keep it if it lands inside the ram
         flag_we        = (32'(eff_index) < FLAG_BYTES);
         header_left_in = eff_header - 6'd1;
         point_index_in = (eff_header == 6'd1) ? 7'd0 : eff_index + 7'd1;
      end else if (eff_points != 7'd0) begin
         unique case (eff_phase)
            PH_X_LO: begin
               if (x_delta) begin
                  x_acc_in = x_acc_ff + byte_sext;
                  phase_in = PH_Y_LO;
               end else begin
                  low_hold_in = data_byte;
                  phase_in    = PH_X_HI;
               end
            end
            PH_X_HI: begin
               x_acc_in = {data_byte, low_hold_ff};
               phase_in = PH_Y_LO;
            end
            PH_Y_LO: begin
               if (y_delta) begin
                  y_acc_in = y_acc_ff + byte_sext;
                  done     = 1'b1;
               end else begin
                  low_hold_in = data_byte;
                  phase_in    = PH_Y_HI;
               end
            end
            PH_Y_HI: begin
               y_acc_in = {data_byte, low_hold_ff};
               done     = 1'b1;
            end
            default: begin
               phase_in = PH_X_LO;
            end
         endcase
         if (done) begin
            points_left_in = eff_points - 7'd1;
            point_index_in = eff_index + 7'd1;
            phase_in       = PH_X_LO;
         end
      end
      // bytes past the last point fall through with no effect
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_left_ff <= '0;
         points_left_ff <= '0;
         point_index_ff <= '0;
         phase_ff       <= PH_X_LO;
      end else if (accept) begin
         header_left_ff <= header_left_in;
         points_left_ff <= points_left_in;
         point_index_ff <= point_index_in;
         phase_ff       <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         low_hold_ff <= low_hold_in;
         x_acc_ff    <= x_acc_in;
         y_acc_ff    <= y_acc_in;
      end
   end

   // ram write during the header; a flag byte read is only used once the header is
   // done, and never for the point right after it, so no flag byte that is used is
   // read while its entry is being written
   assign flag_wr_addr = eff_index[FLAG_AW-1:0];

   // prefetch the flag byte of the point that is current after this edge
   assign rd_pm1       = (accept ? point_index_in : point_index_ff) - 7'd1;
   assign rd_byte_idx  = rd_pm1 >> 2;
   assign flag_rd_addr = rd_byte_idx[FLAG_AW-1:0];

   always_ff @(posedge clock) begin
      if (accept && flag_we) begin
         flag_mem[flag_wr_addr] <= data_byte;
      end
      flag_rd_ff <= flag_mem[flag_rd_addr];
   end

   // result path
   assign rsp_item.x    = x_acc_in;
   assign rsp_item.y    = y_acc_in;
   assign rsp_item.last = (eff_points == 7'd1);

   wdd_rsp_skid u_rsp_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept && done),
      .in_item   (rsp_item),
      .in_ready  (skid_ready),
      .out_valid (rsp_tvalid),
      .out_item  (rsp_out),
      .out_ready (rsp_tready)
   );

   assign req_tready = skid_ready;
   assign rsp_tdata  = {rsp_out.y, rsp_out.x};
   assign rsp_tlast  = rsp_out.last;

endmodule

`default_nettype wire

[rtl/wdd_core_checker.sv]
// port-level checks for the waypoint delta decoder, bound to the top level
`default_nettype none

module wdd_core_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire [15:0] req_tdata,
   input wire        req_tuser,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata,
   input wire        rsp_tlast
);

   // nothing comes out right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("waypoint presented right after reset");

   // a stalled waypoint holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("waypoint changed while stalled");

   // backpressure only while a waypoint is waiting
   a_ready_needs_pending: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input held off with no waypoint pending");

   // a full skid drains as soon as the output moves
   a_ready_recovers: assert property (@(posedge clock) disable iff (reset)
      !req_tready && rsp_tready |=> req_tready)
      else $error("input still held off after output drained");

   // the first byte of a packet never completes a waypoint
   a_start_no_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser && (!rsp_tvalid || rsp_tready)
         |=> !rsp_tvalid)
      else $error("waypoint produced by a packet's first byte");

endmodule

bind waypoint_delta_decoder_core wdd_core_checker u_wdd_core_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

[verif/waypoint_delta_decoder_core_tb.sv]
// self-checking bench for the waypoint delta decoder core: byte packets in, waypoints checked
module waypoint_delta_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_COORDS    = 256;
   localparam int FLAG_DEPTH    = (MAX_COORDS + 7) / 8;
   localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
   localparam int STALL_LIMIT   = 2000;  // cycles without any handshake
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic [3:0] {
      PH_X_LOW  = 4'b0001,
      PH_X_HIGH = 4'b0010,
      PH_Y_LOW  = 4'b0100,
      PH_Y_HIGH = 4'b1000
   } coord_phase_type;
   typedef enum int {FLAGS_RANDOM, FLAGS_DELTA, FLAGS_ABSOLUTE} flag_mix_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [7:0] data_byte, [15:8] coord_count
   logic        req_tuser = 1'b0; // [0] start_req
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [15:0] x, [31:16] y
   logic        rsp_tlast;

   // decoder state mirrored on the bench side
   logic [7:0]      flag_mem [0:FLAG_DEPTH-1];
   logic [5:0]      hdr_left = '0;
   logic [6:0]      pts_left = '0;
   logic [6:0]      pt_idx = '0;
   coord_phase_type phase = PH_X_LOW;
   logic [7:0]      lo_hold = '0;
   logic [15:0]     cur_x = '0;
   logic [15:0]     cur_y = '0;

   wdd_pkg::rsp_item_type pending_waypoints [$];

   int  mismatches = 0;
   int  quiet_cycles = 0;
   bit  idling_on = 1'b1;
   int  holds_asked = 0;
   int  holds_taken = 0;
   int  hold_left = 0;
   int  stall_left = 0;

   waypoint_delta_decoder_core #(.MAX_COORDS(MAX_COORDS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // flag for the coordinate about to start: 0 picks x, 1 picks y
   function automatic bit coord_is_delta(input int sel);
      int pos;
      if (pt_idx == 0) return 1'b0;
      pos = 2 * (int'(pt_idx) - 1) + sel;
      if (pos / 8 >= FLAG_DEPTH) return 1'b0;
      return flag_mem[pos / 8][pos % 8];
   endfunction

   // advance the decoder by one accepted byte, queue a waypoint when y completes
   function automatic void decode_byte(input logic [7:0] din, input logic start,
                                       input logic [7:0] count);
      int c;
      logic [15:0] ext;
      logic done;
      wdd_pkg::rsp_item_type wp;
      done = 1'b0;
      if (start) begin
         c = count;
         if (c > MAX_COORDS) c = MAX_COORDS;
         hdr_left = 6'((c + 5) / 8 + c % 2);
         pts_left = 7'(c / 2);
         pt_idx   = '0;
         phase    = PH_X_LOW;
         lo_hold  = '0;
      end
      if (hdr_left != 0) begin
         // header bytes past the store are swallowed
         if (pt_idx < FLAG_DEPTH) flag_mem[pt_idx] = din;
         pt_idx++;
         hdr_left--;
         if (hdr_left == 0) pt_idx = '0;
      end else if (pts_left != 0) begin
         ext = {{8{din[7]}}, din};
         case (phase)
            PH_X_LOW: begin
               if (coord_is_delta(0)) begin
                  cur_x = cur_x + ext;
                  phase = PH_Y_LOW;
               end else begin
                  lo_hold = din;
                  phase   = PH_X_HIGH;
               end
            end
            PH_X_HIGH: begin
               cur_x = {din, lo_hold};
               phase = PH_Y_LOW;
            end
            PH_Y_LOW: begin
               if (coord_is_delta(1)) begin
                  cur_y = cur_y + ext;
                  done  = 1'b1;
               end else begin
                  lo_hold = din;
                  phase   = PH_Y_HIGH;
               end
            end
            default: begin
               cur_y = {din, lo_hold};
               done  = 1'b1;
            end
         endcase
         if (done) begin
            wp.x    = cur_x;
            wp.y    = cur_y;
            wp.last = (pts_left == 7'd1);
            pending_waypoints.insert(pending_waypoints.size(), wp);
            pts_left--;
            pt_idx++;
            phase = PH_X_LOW;
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
   endtask

   // called at a falling edge; returns at the falling edge after the item went in
   task automatic send_item(input logic [7:0] din, input logic start, input logic [7:0] count);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {count, din};
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      decode_byte(din, start, count);
      @(negedge clock);
   endtask

   // stop offering and let every pending waypoint come out
   task automatic wait_for_waypoints();
      req_tvalid <= 1'b0;
      while (pending_waypoints.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one well-formed packet with random payload, cut short when broken is set
   task automatic send_packet(input int count, input flag_mix_type mix, input bit broken,
                              output int sent);
      logic [7:0] hdr [0:32];
      int hdr_len, total, pos, k, s;
      hdr_len = (count + 5) / 8 + count % 2;
      for (k = 0; k < hdr_len; k++)
         case (mix)
            FLAGS_DELTA:    hdr[k] = 8'hFF;
            FLAGS_ABSOLUTE: hdr[k] = 8'h00;
            default:        hdr[k] = 8'($urandom);
         endcase
      total = hdr_len;
      for (k = 0; k < count / 2; k++)
         for (s = 0; s < 2; s++) begin
            if (k == 0) begin
               total += 2;
            end else begin
               pos = 2 * (k - 1) + s;
               total += hdr[pos / 8][pos % 8] ? 1 : 2;
            end
         end
      if (total == 0) total = 1;
      if (broken && total > 1) total = $urandom_range(1, total - 1);
      for (k = 0; k < total; k++)
         send_item((k < hdr_len) ? hdr[k] : 8'($urandom), k == 0,
                   (k == 0) ? 8'(count) : 8'($urandom));
      sent = total;
   endtask

   // bytes with no packet open, an empty packet and a header-only packet
   task automatic test_idle_bytes();
      send_item(8'hA5, 1'b0, 8'hFF);
      send_item(8'h00, 1'b1, 8'd0);
      send_item(8'h5A, 1'b1, 8'd1);
   endtask

   // single absolute point at the coordinate extremes
   task automatic test_absolute_extremes();
      send_item(8'hFF, 1'b1, 8'd2);
      send_item(8'h7F, 1'b0, 8'h00);
      send_item(8'h00, 1'b0, 8'h00);
      send_item(8'h80, 1'b0, 8'h00);
   endtask

   // deltas that wrap both coordinates, then a stray byte after the last point
   task automatic test_delta_wrap();
      send_item(8'hFF, 1'b1, 8'd4);
      send_item(8'hFF, 1'b0, 8'h00);
      send_item(8'hFF, 1'b0, 8'h00);
      send_item(8'h00, 1'b0, 8'h00);
      send_item(8'h80, 1'b0, 8'h00);
      send_item(8'h01, 1'b0, 8'h00);
      send_item(8'hFF, 1'b0, 8'h00);
      send_item(8'h42, 1'b0, 8'h00);
   endtask

   // odd count: extra header byte, then absolute x with a -128 delta on y
   task automatic test_mixed_flags();
      send_item(8'h02, 1'b1, 8'd5);
      send_item(8'hFD, 1'b0, 8'h00);
      send_item(8'h34, 1'b0, 8'h00);
      send_item(8'h12, 1'b0, 8'h00);
      send_item(8'hCD, 1'b0, 8'h00);
      send_item(8'hAB, 1'b0, 8'h00);
      send_item(8'h00, 1'b0, 8'h00);
      send_item(8'h80, 1'b0, 8'h00);
      send_item(8'h80, 1'b0, 8'h00);
   endtask

   // a new start inside a header and inside a point drops the open packet
   task automatic test_restart_mid_packet();
      send_item(8'hFF, 1'b1, 8'd17);
      send_item(8'h00, 1'b1, 8'd9);
      send_item(8'h00, 1'b0, 8'h00);
      send_item(8'h11, 1'b0, 8'h00);
      send_item(8'h22, 1'b0, 8'h00);
      send_item(8'h33, 1'b1, 8'd2);
      send_item(8'h44, 1'b0, 8'h00);
      send_item(8'h55, 1'b0, 8'h00);
      send_item(8'h66, 1'b0, 8'h00);
   endtask

   // largest count: the header runs one byte past the flag store
   task automatic test_max_count();
      int sent;
      send_packet(255, FLAGS_DELTA, 1'b0, sent);
      wait_for_waypoints();
   endtask

   // receiver holds off while a dense packet keeps coming, then the sender drains
   task automatic test_backpressure();
      int sent;
      holds_asked++;
      send_packet(60, FLAGS_DELTA, 1'b0, sent);
      wait_for_waypoints();
   endtask

   task automatic test_random_packets(input int budget);
      int sent_total, sent, count, r;
      flag_mix_type mix;
      sent_total = 0;
      while (sent_total < budget) begin
         r = $urandom_range(0, 19);
         if (r < 2)       count = $urandom_range(0, 3);
         else if (r < 16) count = $urandom_range(4, 40);
         else if (r < 19) count = $urandom_range(41, 120);
         else             count = $urandom_range(0, 255);
         r = $urandom_range(0, 9);
         mix = (r < 6) ? FLAGS_RANDOM : (r < 8) ? FLAGS_DELTA : FLAGS_ABSOLUTE;
         send_packet(count, mix, $urandom_range(0, 7) == 0, sent);
         sent_total += sent;
         // stray bytes between packets
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) send_item(8'($urandom), 1'b0, 8'($urandom));
      end
   endtask

   // result side ready: long holds on request, random stalls otherwise
   always @(negedge clock) begin
      if (holds_taken != holds_asked) begin
         holds_taken <= holds_taken + 1;
         hold_left   <= HOLD_CYCLES - 1;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 16) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_waypoint
      wdd_pkg::rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_waypoints.size() == 0) begin
            report_mismatch("waypoint with none pending, x", $signed(rsp_tdata[15:0]), 0);
         end else begin
            want = pending_waypoints.pop_front();
            if (rsp_tdata[15:0] !== want.x)
               report_mismatch("x", $signed(rsp_tdata[15:0]), want.x);
            if (rsp_tdata[31:16] !== want.y)
               report_mismatch("y", $signed(rsp_tdata[31:16]), want.y);
            if (rsp_tlast !== want.last)
               report_mismatch("last", rsp_tlast, want.last);
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_idle_bytes();
      test_absolute_extremes();
      test_delta_wrap();
      test_mixed_flags();
      test_restart_mid_packet();
      wait_for_waypoints();
      test_max_count();
      test_backpressure();
      test_random_packets(250);
      // closing stretch runs at full rate on both sides
      idling_on = 1'b0;
      test_random_packets(60);
      wait_for_waypoints();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
